FILE: src/ptdt_pkg.sv
// shared types for the periodic task dispatch table
package ptdt_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned MaskW  = 8;

  typedef enum logic [0:0] {
    FUNC_TICK   = 1'b0,
    FUNC_CREATE = 1'b1
  } func_e;

  // one task slot as it travels round the ring
  typedef struct packed {
    logic              ready;
    logic [CountW-1:0] period;
    logic [CountW-1:0] count;
  } slot_rec_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic      shift;
    logic      load;
    slot_rec_t load_rec;
  } cell_ctl_t;

endpackage

FILE: src/ptdt_cell.sv
// one slot cell of the dispatch ring: holds a record, optionally updates it as it passes
module ptdt_cell import ptdt_pkg::*; #(
  parameter bit Process = 1'b0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  slot_rec_t rec_i,
  output slot_rec_t rec_o,
  output logic      fire_o
);

  slot_rec_t rec_q, rec_d, upd;
  logic      due;

  // due: ready slot with an expired countdown
  assign due = rec_i.ready && (rec_i.count == '0);

  always_comb begin
    upd = rec_i;
    if (Process && rec_i.ready) begin
      if (due) upd.count = rec_i.period;
      else     upd.count = rec_i.count - CountW'(1);
    end
  end

  always_comb begin
    rec_d = rec_q;
    if (ctl_i.load)       rec_d = ctl_i.load_rec;
    else if (ctl_i.shift) rec_d = upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o  = rec_q;
  assign fire_o = Process && due;

endmodule

FILE: src/periodic_task_dispatch_table_core.sv
// top level of the periodic task dispatch table: slot ring and tick sequencer
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------------------------
//  command   in         start high, busy low      func_i slot_i period_i first_delay_i
//                                                 has_callback_i
//  result    out        result_valid_o, 1 cycle   fire_mask_o tick_count_o
//
// a create beat is taken at once and writes its cell directly; busy stays low.
// a tick beat rotates the ring of NUM_SLOTS cells once, one slot through the update
// cell per cycle, with busy high for the whole walk; the result strobe follows in
// the next cycle, in which a new beat may already be taken.
// reset clears every cell, the tick counter and the sequencer.
// the receiver cannot stall: each result shows for exactly one cycle.
module periodic_task_dispatch_table_core import ptdt_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              func_i,
  input  logic [2:0]        slot_i,
  input  logic [CountW-1:0] period_i,
  input  logic [CountW-1:0] first_delay_i,
  input  logic              has_callback_i,
  output logic              result_valid_o,
  output logic [MaskW-1:0]  fire_mask_o,
  output logic [CountW-1:0] tick_count_o
);

  localparam int unsigned StepW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned ExtW  = (NUM_SLOTS > MaskW) ? NUM_SLOTS : MaskW;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [NUM_SLOTS-1:0] mask_q, mask_d;
  logic [CountW-1:0]  ticks_q, ticks_d;
  logic               valid_q, valid_d;
  logic [MaskW-1:0]   res_mask_q, res_mask_d;
  logic [CountW-1:0]  res_tick_q, res_tick_d;

  logic      accept, create, tick, last_step, fire;
  slot_rec_t new_rec;
  slot_rec_t ring [NUM_SLOTS];
  logic      fires [NUM_SLOTS];
  logic [ExtW-1:0] mask_ext;

  assign busy      = (state_q == ST_WALK);
  assign accept    = start && !busy;
  assign create    = accept && (func_i == FUNC_CREATE);
  assign tick      = accept && (func_i == FUNC_TICK);
  assign last_step = (step_q == StepW'(NUM_SLOTS - 1));

  assign new_rec.ready  = has_callback_i;
  assign new_rec.period = period_i;
  assign new_rec.count  = first_delay_i;

  // ring of cells: cell i takes cell i-1, cell 0 takes the last one through the update
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.shift    = busy;
    // only slots reachable by the 3-bit slot field can ever be written
    assign ctl.load     = create && (32'(slot_i) == i);
    assign ctl.load_rec = new_rec;

    ptdt_cell #(
      .Process(i == 0)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .rec_i (ring[(i + NUM_SLOTS - 1) % NUM_SLOTS]),
      .rec_o (ring[i]),
      .fire_o(fires[i])
    );
  end

  assign fire = fires[0];

  // at step k the update cell sees slot NUM_SLOTS-1-k, so shifting in at the bottom
  // leaves each slot's bit in its own place after the last step
  always_comb begin
    mask_d[0] = fire;
    for (int unsigned j = 1; j < NUM_SLOTS; j++) begin
      mask_d[j] = mask_q[j-1];
    end
  end

  assign mask_ext = ExtW'(mask_d);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    ticks_d    = ticks_q;
    valid_d    = 1'b0;
    res_mask_d = res_mask_q;
    res_tick_d = res_tick_q;
    case (state_q)
      ST_IDLE: begin
        if (tick) begin
          state_d = ST_WALK;
          step_d  = '0;
        end
      end
      ST_WALK: begin
        step_d = step_q + StepW'(1);
        if (last_step) begin
          state_d    = ST_IDLE;
          valid_d    = 1'b1;
          res_mask_d = mask_ext[MaskW-1:0];
          res_tick_d = ticks_q;
          ticks_d    = ticks_q + CountW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      ticks_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ticks_q <= ticks_d;
      valid_q <= valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (busy) mask_q <= mask_d;
    res_mask_q <= res_mask_d;
    res_tick_q <= res_tick_d;
  end

  assign result_valid_o = valid_q;
  assign fire_mask_o    = res_mask_q;
  assign tick_count_o   = res_tick_q;

endmodule

FILE: src/ptdt_checker.sv
// port-level checker for the dispatch table core and its bind
module ptdt_checker import ptdt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              func_i,
  input logic              result_valid_o
);

  // a tick beat starts a walk
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FUNC_TICK) |=> busy)
    else $error("tick beat did not start a walk");

  // a create beat neither walks nor answers
  a_create_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FUNC_CREATE) |=> (!busy && !result_valid_o))
    else $error("create beat caused activity");

  // a result only ends a walk
  a_result_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy) && !busy))
    else $error("result without a walk");

  // end of a walk always gives a result
  a_walk_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("walk ended without a result");

endmodule

bind periodic_task_dispatch_table_core ptdt_checker u_ptdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .func_i        (func_i),
  .result_valid_o(result_valid_o)
);

FILE: verif/tb_periodic_task_dispatch_table_core.sv
// testbench for the periodic task dispatch table core, checked beat by beat against a predictor
`timescale 1ns / 1ps

module tb_periodic_task_dispatch_table_core;
  import ptdt_pkg::*;

  localparam int unsigned NUM_SLOTS   = 8;
  // longest quiet spell is a sender gap plus one full ring walk, far below this
  localparam int unsigned STALL_LIMIT = 1000;

  // what one tick should report
  typedef struct packed {
    logic [MaskW-1:0]  fire_mask;
    logic [CountW-1:0] tick_count;
  } dispatch_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              func_i;
  logic [2:0]        slot_i;
  logic [CountW-1:0] period_i;
  logic [CountW-1:0] first_delay_i;
  logic              has_callback_i;
  logic              result_valid_o;
  logic [MaskW-1:0]  fire_mask_o;
  logic [CountW-1:0] tick_count_o;

  // predictor state: one copy of the slot table and the tick counter
  logic [CountW-1:0] slot_period [NUM_SLOTS];
  logic [CountW-1:0] slot_count  [NUM_SLOTS];
  logic              slot_armed  [NUM_SLOTS];
  logic [CountW-1:0] tick_ctr;

  dispatch_t   dispatch_q[$];   // dispatches still owed by the block, oldest first
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  periodic_task_dispatch_table_core #(
    .NUM_SLOTS(NUM_SLOTS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .slot_i        (slot_i),
    .period_i      (period_i),
    .first_delay_i (first_delay_i),
    .has_callback_i(has_callback_i),
    .result_valid_o(result_valid_o),
    .fire_mask_o   (fire_mask_o),
    .tick_count_o  (tick_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // apply one accepted beat to the slot table; a tick queues its dispatch
  task automatic predict_beat(input func_e f, input logic [2:0] s,
                              input logic [CountW-1:0] p, input logic [CountW-1:0] d,
                              input logic cb);
    dispatch_t due;
    if (f == FUNC_CREATE) begin
      // a slot number past the table is dropped silently
      if (s < NUM_SLOTS) begin
        slot_period[s] = p;
        slot_count[s]  = d;
        slot_armed[s]  = cb;
      end
    end else begin
      due.fire_mask  = '0;
      due.tick_count = tick_ctr;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_armed[i]) begin
          if (slot_count[i] == '0) begin
            // due now: reload and flag it, if the slot has a mask bit at all
            slot_count[i] = slot_period[i];
            if (i < MaskW) due.fire_mask[i] = 1'b1;
          end else begin
            slot_count[i] = slot_count[i] - 1'b1;
          end
        end
      end
      tick_ctr = tick_ctr + 1'b1;
      dispatch_q.push_back(due);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // present one beat and hold it until the block takes it; start is left high
  // so that a following beat in the same burst goes straight out
  task automatic send_beat(input func_e f, input logic [2:0] s,
                           input logic [CountW-1:0] p, input logic [CountW-1:0] d,
                           input logic cb);
    start          <= 1'b1;
    func_i         <= f;
    slot_i         <= s;
    period_i       <= p;
    first_delay_i  <= d;
    has_callback_i <= cb;
    do @(posedge clk_i); while (busy);
    predict_beat(f, s, p, d, cb);
  endtask

  // tick with junk in the fields the block should not look at
  task automatic send_tick();
    send_beat(FUNC_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // drop start for an idle gap of n (n at least one) with junk on the payload
  task automatic idle_gap(input int unsigned n);
    start          <= 1'b0;
    func_i         <= 1'($urandom);
    slot_i         <= 3'($urandom);
    period_i       <= 16'($urandom);
    first_delay_i  <= 16'($urandom);
    has_callback_i <= 1'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  // mostly short spans so slots fire often, now and then the full range
  function automatic logic [CountW-1:0] pick_span();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return CountW'($urandom_range(0, 7));
    if (roll < 85) return CountW'($urandom_range(8, 63));
    return CountW'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // each strobe is one result beat; compare it with the oldest owed dispatch
  always @(posedge clk_i) begin
    dispatch_t want;
    if (rst_ni && result_valid_o) begin
      if (dispatch_q.size() == 0) begin
        report_mismatch("result with no tick outstanding", 32'(tick_count_o), 0);
      end else begin
        want = dispatch_q.pop_front();
        if (fire_mask_o !== want.fire_mask)
          report_mismatch("fire_mask", 32'(fire_mask_o), 32'(want.fire_mask));
        if (tick_count_o !== want.tick_count)
          report_mismatch("tick_count", 32'(tick_count_o), 32'(want.tick_count));
      end
    end
  end

  // watchdog: any beat taken in either direction counts as progress
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked beats: empty table, field extremes, no callback, zero period
  task automatic test_directed();
    send_tick();                                          // nothing armed yet
    send_beat(FUNC_CREATE, 3'd0, 16'h0000, 16'h0000, 1'b1); // zero period, fires every tick
    send_beat(FUNC_CREATE, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1); // largest period and delay
    send_beat(FUNC_CREATE, 3'd3, 16'h0002, 16'h0001, 1'b0); // no callback, never fires
    send_beat(FUNC_CREATE, 3'd5, 16'h0001, 16'h0002, 1'b1);
    send_beat(FUNC_CREATE, 3'd1, 16'hAAAA, 16'h5555, 1'b1);
    send_beat(FUNC_CREATE, 3'd2, 16'h5555, 16'h0000, 1'b1); // fires once, then waits long
    repeat (6) send_tick();
    idle_gap(3);
    send_beat(FUNC_CREATE, 3'd0, 16'h0003, 16'h0000, 1'b0); // disarm a live slot
    send_beat(FUNC_CREATE, 3'd6, 16'h0000, 16'h0001, 1'b1);
    send_beat(FUNC_CREATE, 3'd4, 16'h0001, 16'h0000, 1'b1);
    repeat (4) send_tick();
    send_beat(FUNC_CREATE, 3'd7, 16'h0000, 16'h0000, 1'b1); // top mask bit on every tick
    repeat (3) send_tick();
    idle_gap(5);
  endtask

  // random mix in bursts: mostly ticks and armed creates, some disarming noise
  task automatic test_random_mix(input int unsigned n_beats);
    int unsigned burst_left;
    burst_left = $urandom_range(1, 24);
    repeat (n_beats) begin
      if ($urandom_range(0, 99) < 65) begin
        send_tick();
      end else begin
        send_beat(FUNC_CREATE, 3'($urandom), pick_span(), pick_span(),
                  ($urandom_range(0, 99) < 80));
      end
      burst_left--;
      if (burst_left == 0) begin
        // a quarter of the bursts run straight into the next one
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 15));
        burst_left = $urandom_range(1, 24);
      end
    end
    idle_gap(2);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_period[i] = '0;
      slot_count[i]  = '0;
      slot_armed[i]  = 1'b0;
    end
    tick_ctr       = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;

    rst_ni         <= 1'b0;
    start          <= 1'b0;
    func_i         <= FUNC_TICK;
    slot_i         <= '0;
    period_i       <= '0;
    first_delay_i  <= '0;
    has_callback_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix(1850);

    // let the last dispatch come out, then allow one ring walk of slack
    while (dispatch_q.size() != 0) @(posedge clk_i);
    repeat (NUM_SLOTS + 4) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
